FILE: rtl/mmwb_pkg.sv
// ----------------------------------------------------------------------------
// mmwb_pkg: shared constants and types of the memory-mapped word bus
// Holds the RAM geometry, request and result codes, register reset values
// and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package mmwb_pkg;

    // Byte RAM geometry
    localparam int                RAM_BYTES      = 65536;
    localparam int                RAM_AW         = $clog2(RAM_BYTES);
    localparam logic [31:0]       RAM_END        = 32'(RAM_BYTES);
    localparam logic [31:0]       RAM_LAST_START = 32'(RAM_BYTES - 4);
    localparam logic [RAM_AW-1:0] RAM_TOP        = RAM_AW'(RAM_BYTES - 1);

    // Request commands
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_STORE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_LOAD    = 2'd0;
    localparam logic [1:0] KIND_STORE   = 2'd1;
    localparam logic [1:0] KIND_CONSOLE = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    // Configuration port
    localparam int          PADDR_W           = 3;
    localparam logic        REG_CONSOLE       = 1'b0;
    localparam logic        REG_TIMER         = 1'b1;
    localparam logic [31:0] CONSOLE_ADDR_RST  = 32'd65536;
    localparam logic [31:0] TIMER_ADDR_RST    = 32'd65537;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_RD_TAIL,
        ST_WR,
        ST_PUT
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/mmwb_ram.sv
// ----------------------------------------------------------------------------
// mmwb_ram: generic RAM with one write port and one registered read port
// Write and read addresses are independent; read data is registered and
// appears in the cycle after the address.
// ----------------------------------------------------------------------------
`default_nettype none

module mmwb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/memory_mapped_word_bus.sv
// ----------------------------------------------------------------------------
// memory_mapped_word_bus: big-endian word bus with byte RAM, console, timer
// Decodes each request to RAM, console port or timer port and moves the
// word one byte per cycle through the byte-wide RAM, whose two ports share one address.
//
//   channel   direction  handshake              payload
//   request   in         in_valid / in_ready    cmd, byte_address, store_data
//   result    out        out_valid / out_ready  kind, load_data, console_byte,
//                                               last
//   config    in         APB psel/penable       paddr, pwdata, prdata
//
// RAM load: 4 byte reads, the registered read data shifted into the word,
//   then the result load; the next request is taken once the result is loaded.
// RAM store: 4 byte writes, then the result load; the next request is
//   taken once the result is loaded.
// Console store: 4 results, one per cycle while out_ready stays high.
// Other requests: the result load follows the accept, next request once loaded;
//   a tick or an unused command gives no result and the next request can follow at once.
// After reset the RAM is cleared one byte per cycle, all 65536 bytes, with
// in_ready low; configuration writes are taken meanwhile.
// A stalled result holds in the output register; the next request is
// accepted while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module memory_mapped_word_bus (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // request channel
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [1:0]                   cmd,
    input  wire logic [31:0]                  byte_address,
    input  wire logic [31:0]                  store_data,
    // result channel
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic      [1:0]                   kind,
    output logic      [31:0]                  load_data,
    output logic      [7:0]                   console_byte,
    output logic                              last,
    // configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [mmwb_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready
);

    localparam int AW = mmwb_pkg::RAM_AW;

    // Control state
    mmwb_pkg::state_t state_reg, state_next;
    logic [AW-1:0]    ptr_reg, ptr_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic [7:0]       ms_reg, ms_next;
    logic [31:0]      console_addr_reg, console_addr_next;
    logic [31:0]      timer_addr_reg, timer_addr_next;
    logic             out_valid_reg, out_valid_next;
    logic             rd_issued_reg, rd_issued_next;

    // Payload state
    logic [31:0]      data_reg, data_next;
    logic [1:0]       res_kind_reg, res_kind_next;
    logic [1:0]       out_kind_reg, out_kind_next;
    logic [31:0]      out_data_reg, out_data_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_last_reg, out_last_next;

    // Sequencer outputs
    logic             in_fire;
    logic             slot_free;
    logic             step;
    logic             put_load;
    logic             put_last;
    logic             ram_we;
    logic [7:0]       ram_wdata;
    logic [7:0]       ram_rdata;

    // Request decode
    logic             is_access;
    logic             in_ram;
    logic             past_end;
    logic             ram_ok;
    logic             is_console;
    logic             is_timer;
    logic             cfg_write;

    assign in_fire   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign cfg_write = psel && penable && pwrite;

    assign is_access  = (cmd == mmwb_pkg::CMD_LOAD) || (cmd == mmwb_pkg::CMD_STORE);
    assign in_ram     = byte_address < mmwb_pkg::RAM_END;
    assign past_end   = byte_address > mmwb_pkg::RAM_LAST_START;
    assign ram_ok     = in_ram && !past_end;
    assign is_console = byte_address == console_addr_reg;
    assign is_timer   = byte_address == timer_addr_reg;

    assign put_last = (res_kind_reg != mmwb_pkg::KIND_CONSOLE) || (cnt_reg == 2'd3);

    // Byte RAM
    mmwb_ram #(
        .WIDTH (8),
        .DEPTH (mmwb_pkg::RAM_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ptr_reg),
        .wdata (ram_wdata),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mmwb_pkg::ST_CLEAR:
            begin
                if (ptr_reg == mmwb_pkg::RAM_TOP)
                begin
                    state_next = mmwb_pkg::ST_IDLE;
                end
            end
            mmwb_pkg::ST_IDLE:
            begin
                if (in_fire && is_access)
                begin
                    if (in_ram && ram_ok)
                    begin
                        state_next = (cmd == mmwb_pkg::CMD_LOAD) ? mmwb_pkg::ST_RD
                                                                  : mmwb_pkg::ST_WR;
                    end
                    else
                    begin
                        state_next = mmwb_pkg::ST_PUT;
                    end
                end
            end
            mmwb_pkg::ST_RD:
            begin
                if (cnt_reg == 2'd3)
                begin
                    state_next = mmwb_pkg::ST_RD_TAIL;
                end
            end
            mmwb_pkg::ST_RD_TAIL:
            begin
                state_next = mmwb_pkg::ST_PUT;
            end
            mmwb_pkg::ST_WR:
            begin
                if (cnt_reg == 2'd3)
                begin
                    state_next = mmwb_pkg::ST_PUT;
                end
            end
            mmwb_pkg::ST_PUT:
            begin
                if (slot_free && put_last)
                begin
                    state_next = mmwb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mmwb_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_ready  = 1'b0;
        ram_we    = 1'b0;
        ram_wdata = 8'd0;
        step      = 1'b0;
        put_load  = 1'b0;
        case (state_reg)
            mmwb_pkg::ST_CLEAR:
            begin
                ram_we = 1'b1;
                step   = 1'b1;
            end
            mmwb_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            mmwb_pkg::ST_RD:
            begin
                step = 1'b1;
            end
            mmwb_pkg::ST_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = data_reg[31:24];
                step      = 1'b1;
            end
            mmwb_pkg::ST_PUT:
            begin
                put_load = slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        ptr_next          = ptr_reg;
        cnt_next          = cnt_reg;
        ms_next           = ms_reg;
        data_next         = data_reg;
        res_kind_next     = res_kind_reg;
        console_addr_next = console_addr_reg;
        timer_addr_next   = timer_addr_reg;
        rd_issued_next    = (state_reg == mmwb_pkg::ST_RD);
        out_valid_next    = out_valid_reg;
        out_kind_next     = out_kind_reg;
        out_data_next     = out_data_reg;
        out_byte_next     = out_byte_reg;
        out_last_next     = out_last_reg;

        // Advance the byte pointer and lane counter
        if (in_fire)
        begin
            ptr_next = byte_address[AW-1:0];
            cnt_next = 2'd0;
        end
        else
        begin
            if (step)
            begin
                ptr_next = ptr_reg + AW'(1);
            end
            if ((state_reg == mmwb_pkg::ST_RD) || (state_reg == mmwb_pkg::ST_WR) ||
                (put_load && (res_kind_reg == mmwb_pkg::KIND_CONSOLE)))
            begin
                cnt_next = cnt_reg + 2'd1;
            end
        end

        // Count ticks
        if (in_fire && (cmd == mmwb_pkg::CMD_TICK))
        begin
            ms_next = ms_reg + 8'd1;
        end

        // Classify the request and set up the word
        if (in_fire && is_access)
        begin
            data_next = 32'd0;
            if (in_ram)
            begin
                if (!ram_ok)
                begin
                    res_kind_next = mmwb_pkg::KIND_ERROR;
                end
                else if (cmd == mmwb_pkg::CMD_LOAD)
                begin
                    res_kind_next = mmwb_pkg::KIND_LOAD;
                end
                else
                begin
                    res_kind_next = mmwb_pkg::KIND_STORE;
                    data_next     = store_data;
                end
            end
            else if (is_console)
            begin
                if (cmd == mmwb_pkg::CMD_LOAD)
                begin
                    res_kind_next = mmwb_pkg::KIND_LOAD;
                end
                else
                begin
                    res_kind_next = mmwb_pkg::KIND_CONSOLE;
                    data_next     = store_data;
                end
            end
            else if (is_timer)
            begin
                if (cmd == mmwb_pkg::CMD_LOAD)
                begin
                    res_kind_next = mmwb_pkg::KIND_LOAD;
                    data_next     = {4{ms_reg}};
                end
                else
                begin
                    res_kind_next = mmwb_pkg::KIND_STORE;
                end
            end
            else
            begin
                res_kind_next = mmwb_pkg::KIND_ERROR;
            end
        end
        else if (state_reg == mmwb_pkg::ST_WR)
        begin
            data_next = {data_reg[23:0], 8'd0};
        end
        else if (rd_issued_reg)
        begin
            data_next = {data_reg[23:0], ram_rdata};
        end
        else if (put_load && (res_kind_reg == mmwb_pkg::KIND_CONSOLE))
        begin
            data_next = {data_reg[23:0], 8'd0};
        end

        // Load the result register when it is free
        if (put_load)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = res_kind_reg;
            out_data_next  = (res_kind_reg == mmwb_pkg::KIND_LOAD) ? data_reg : 32'd0;
            out_byte_next  = (res_kind_reg == mmwb_pkg::KIND_CONSOLE) ? data_reg[31:24]
                                                                       : 8'd0;
            out_last_next  = put_last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // Register writes
        if (cfg_write)
        begin
            case (paddr[2])
                mmwb_pkg::REG_CONSOLE: console_addr_next = pwdata;
                mmwb_pkg::REG_TIMER:   timer_addr_next   = pwdata;
                default:               console_addr_next = console_addr_reg;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= mmwb_pkg::ST_CLEAR;
            ptr_reg          <= '0;
            cnt_reg          <= 2'd0;
            ms_reg           <= 8'd0;
            console_addr_reg <= mmwb_pkg::CONSOLE_ADDR_RST;
            timer_addr_reg   <= mmwb_pkg::TIMER_ADDR_RST;
            out_valid_reg    <= 1'b0;
            rd_issued_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            ptr_reg          <= ptr_next;
            cnt_reg          <= cnt_next;
            ms_reg           <= ms_next;
            console_addr_reg <= console_addr_next;
            timer_addr_reg   <= timer_addr_next;
            out_valid_reg    <= out_valid_next;
            rd_issued_reg    <= rd_issued_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        data_reg     <= data_next;
        res_kind_reg <= res_kind_next;
        out_kind_reg <= out_kind_next;
        out_data_reg <= out_data_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    // Ports
    assign out_valid    = out_valid_reg;
    assign kind         = out_kind_reg;
    assign load_data    = out_data_reg;
    assign console_byte = out_byte_reg;
    assign last         = out_last_reg;
    assign prdata       = (paddr[2] == mmwb_pkg::REG_TIMER) ? timer_addr_reg
                                                            : console_addr_reg;
    assign pready       = 1'b1;

    // A result without last is a console byte with more to follow
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last) |-> (state_reg == mmwb_pkg::ST_PUT))
        else $error("non-final result taken with no further result pending");

    // A load or store keeps the bus busy in the following cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready &&
         (cmd == mmwb_pkg::CMD_LOAD || cmd == mmwb_pkg::CMD_STORE)) |=> !in_ready)
        else $error("request accepted while previous access in progress");

    // Word results find the lane counter at zero, after a full four-byte pass for RAM accesses
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mmwb_pkg::ST_PUT && res_kind_reg != mmwb_pkg::KIND_CONSOLE)
        |-> (cnt_reg == 2'd0))
        else $error("lane counter misaligned at result");

    // The final byte of a RAM read lands right after the last read issue
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mmwb_pkg::ST_RD_TAIL) |-> (rd_issued_reg && $past(cnt_reg) == 2'd3))
        else $error("read tail entered without four byte reads");

endmodule

`default_nettype wire

FILE: bench/mmwb_result_checker.sv
// ----------------------------------------------------------------------------
// mmwb_result_checker: result predictor and comparator for the word bus
// Watches the request, result and register ports. It keeps its own RAM
// image, tick count and port addresses, works out the results each accepted
// request should give, and compares every accepted result with the oldest
// one still due. Mismatches are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module mmwb_result_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // request channel
    input  wire logic                         in_valid,
    input  wire logic                         in_ready,
    input  wire logic [1:0]                   cmd,
    input  wire logic [31:0]                  byte_address,
    input  wire logic [31:0]                  store_data,
    // result channel
    input  wire logic                         out_valid,
    input  wire logic                         out_ready,
    input  wire logic [1:0]                   kind,
    input  wire logic [31:0]                  load_data,
    input  wire logic [7:0]                   console_byte,
    input  wire logic                         last,
    // register port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [mmwb_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    input  wire logic [31:0]                  prdata,
    input  wire logic                         pready,
    // status to the top
    output int                                fail_count,
    output int                                replies_due
);

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] load_data;
        logic [7:0]  console_byte;
        logic        last;
    } bus_reply_t;

    localparam logic [mmwb_pkg::PADDR_W-1:0] CONSOLE_REG_ADDR =
        mmwb_pkg::PADDR_W'({mmwb_pkg::REG_CONSOLE, 2'b00});
    localparam logic [mmwb_pkg::PADDR_W-1:0] TIMER_REG_ADDR =
        mmwb_pkg::PADDR_W'({mmwb_pkg::REG_TIMER, 2'b00});

    logic [7:0]  ram_image [mmwb_pkg::RAM_BYTES];
    logic [7:0]  tick_count;
    logic [31:0] console_port;
    logic [31:0] timer_port;
    bus_reply_t  pending_replies [$];

    // Work out the results of one request and update the mirrored state
    task automatic model_bus_request(input logic [1:0] op, input logic [31:0] addr,
                                     input logic [31:0] data);
        bus_reply_t reply;
        reply      = '0;
        reply.last = 1'b1;
        case (op)
            mmwb_pkg::CMD_TICK:
            begin
                tick_count = tick_count + 8'd1;
            end
            mmwb_pkg::CMD_LOAD, mmwb_pkg::CMD_STORE:
            begin
                if (addr < mmwb_pkg::RAM_END)
                begin
                    // a word whose last byte falls off the RAM is refused whole
                    if (addr > mmwb_pkg::RAM_LAST_START)
                    begin
                        reply.kind = mmwb_pkg::KIND_ERROR;
                    end
                    else if (op == mmwb_pkg::CMD_LOAD)
                    begin
                        reply.kind      = mmwb_pkg::KIND_LOAD;
                        reply.load_data = {ram_image[addr], ram_image[addr + 1],
                                           ram_image[addr + 2], ram_image[addr + 3]};
                    end
                    else
                    begin
                        for (int k = 0; k < 4; k++)
                        begin
                            ram_image[addr + k] = data[31 - 8 * k -: 8];
                        end
                        reply.kind = mmwb_pkg::KIND_STORE;
                    end
                end
                else if (addr == console_port)
                begin
                    // console wins over the timer at the same address
                    if (op == mmwb_pkg::CMD_LOAD)
                    begin
                        reply.kind = mmwb_pkg::KIND_LOAD;
                    end
                    else
                    begin
                        reply.kind = mmwb_pkg::KIND_CONSOLE;
                        reply.last = 1'b0;
                        for (int k = 0; k < 3; k++)
                        begin
                            reply.console_byte = data[31 - 8 * k -: 8];
                            pending_replies.push_back(reply);
                        end
                        reply.console_byte = data[7:0];
                        reply.last         = 1'b1;
                    end
                end
                else if (addr == timer_port)
                begin
                    if (op == mmwb_pkg::CMD_LOAD)
                    begin
                        reply.kind      = mmwb_pkg::KIND_LOAD;
                        reply.load_data = {4{tick_count}};
                    end
                    else
                    begin
                        reply.kind = mmwb_pkg::KIND_STORE;
                    end
                end
                else
                begin
                    reply.kind = mmwb_pkg::KIND_ERROR;
                end
                pending_replies.push_back(reply);
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bus_reply_t got;
        bus_reply_t want;
        logic [31:0] reg_want;
        if (!rst_n)
        begin
            for (int i = 0; i < mmwb_pkg::RAM_BYTES; i++)
            begin
                ram_image[i] = 8'h00;
            end
            tick_count   = 8'h00;
            console_port = mmwb_pkg::CONSOLE_ADDR_RST;
            timer_port   = mmwb_pkg::TIMER_ADDR_RST;
            pending_replies.delete();
            fail_count   = 0;
            replies_due  = 0;
        end
        else
        begin
            // compare an accepted result with the oldest one due
            if (out_valid && out_ready)
            begin
                got = {kind, load_data, console_byte, last};
                if (pending_replies.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("%0t: unexpected result kind %0d data %h byte %h last %b",
                                 $time, got.kind, got.load_data, got.console_byte, got.last);
                    end
                end
                else
                begin
                    want = pending_replies.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("%0t: result mismatch, expected kind %0d data %h",
                                     $time, want.kind, want.load_data,
                                     " byte %h last %b, got kind %0d data %h",
                                     want.console_byte, want.last, got.kind,
                                     got.load_data, " byte %h last %b",
                                     got.console_byte, got.last);
                        end
                    end
                end
            end

            // predict the results of an accepted request
            if (in_valid && in_ready)
            begin
                model_bus_request(cmd, byte_address, store_data);
            end

            // track register writes and check register reads
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr == CONSOLE_REG_ADDR)
                    begin
                        console_port = pwdata;
                    end
                    else if (paddr == TIMER_REG_ADDR)
                    begin
                        timer_port = pwdata;
                    end
                end
                else
                begin
                    reg_want = (paddr == TIMER_REG_ADDR) ? timer_port : console_port;
                    if (prdata !== reg_want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("%0t: register read at %h, expected %h, got %h",
                                     $time, paddr, reg_want, prdata);
                        end
                    end
                end
            end

            replies_due = pending_replies.size();
        end
    end

endmodule

FILE: bench/tb_memory_mapped_word_bus.sv
// ----------------------------------------------------------------------------
// tb_memory_mapped_word_bus: testbench for the memory-mapped word bus
// Drives word loads, stores and ticks over RAM, console and timer, first a
// short directed list, then random requests under several port settings
// and idle patterns, including a long result stall. A checker module beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_memory_mapped_word_bus;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         WINDOW_BYTES = 64;
    localparam int         QUIET_CYCLES = 16;
    localparam int         NUM_PHASES   = 5;
    localparam int         PHASE_ITEMS  = 4;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         STALL_STORES = 6;

    logic                           clk          = 1'b0;
    logic                           rst_n        = 1'b0;
    logic                           in_valid     = 1'b0;
    logic                           in_ready;
    logic [1:0]                     cmd          = mmwb_pkg::CMD_LOAD;
    logic [31:0]                    byte_address = '0;
    logic [31:0]                    store_data   = '0;
    logic                           out_valid;
    logic                           out_ready    = 1'b0;
    logic [1:0]                     kind;
    logic [31:0]                    load_data;
    logic [7:0]                     console_byte;
    logic                           last;
    logic                           psel         = 1'b0;
    logic                           penable      = 1'b0;
    logic                           pwrite       = 1'b0;
    logic [mmwb_pkg::PADDR_W-1:0]   paddr        = '0;
    logic [31:0]                    pwdata       = '0;
    logic [31:0]                    prdata;
    logic                           pready;

    int                             fail_count;
    int                             replies_due;
    int                             send_idle_pct = 0;
    int                             recv_idle_pct = 0;
    int                             hold_requests = 0;
    logic [31:0]                    port_console  = mmwb_pkg::CONSOLE_ADDR_RST;
    logic [31:0]                    port_timer    = mmwb_pkg::TIMER_ADDR_RST;

    memory_mapped_word_bus uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .byte_address (byte_address),
        .store_data   (store_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .load_data    (load_data),
        .console_byte (console_byte),
        .last         (last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    mmwb_result_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .byte_address (byte_address),
        .store_data   (store_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .load_data    (load_data),
        .console_byte (console_byte),
        .last         (last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .fail_count   (fail_count),
        .replies_due  (replies_due)
    );

    always #2 clk = ~clk;

    // Bound the run
    initial
    begin
        #4000000;
        $display("FAILED: results differ");
        $finish;
    end

    // Drive result ready: a long hold when asked, else random stalls
    initial
    begin
        int hold_left;
        int holds_seen;
        hold_left  = 0;
        holds_seen = 0;
        forever
        begin
            @(negedge clk);
            if (holds_seen != hold_requests)
            begin
                holds_seen = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offer one request and hold it until accepted; entered and left at a falling edge
    task automatic send_request(input logic [1:0] op, input logic [31:0] addr,
                                input logic [31:0] data);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        cmd          <= op;
        byte_address <= addr;
        store_data   <= data;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Drop valid and wait until no result is due and the block has settled
    task automatic wait_bus_quiet();
        in_valid <= 1'b0;
        while (replies_due != 0)
        begin
            @(negedge clk);
        end
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    // One register access: setup cycle, then access cycle until pready
    task automatic access_register(input logic write, input logic idx,
                                   input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= mmwb_pkg::PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // One random request, weighted toward RAM reuse and the two ports
    task automatic send_random_request();
        int          roll;
        logic [1:0]  op;
        logic [31:0] addr;
        roll = $urandom_range(99);
        if (roll < 40)
        begin
            op = mmwb_pkg::CMD_LOAD;
        end
        else if (roll < 80)
        begin
            op = mmwb_pkg::CMD_STORE;
        end
        else if (roll < 95)
        begin
            op = mmwb_pkg::CMD_TICK;
        end
        else
        begin
            op = CMD_UNUSED;
        end

        roll = $urandom_range(99);
        if (roll < 45)
        begin
            addr = $urandom_range(WINDOW_BYTES - 1);
        end
        else if (roll < 55)
        begin
            addr = mmwb_pkg::RAM_END - 1 - $urandom_range(15);
        end
        else if (roll < 67)
        begin
            addr = port_console;
        end
        else if (roll < 79)
        begin
            addr = port_timer;
        end
        else if (roll < 85)
        begin
            addr = ($urandom_range(1) ? port_console : port_timer)
                   + ($urandom_range(1) ? 32'd1 : 32'hFFFF_FFFF);
        end
        else
        begin
            addr = $urandom();
        end

        send_request(op, addr, $urandom());
        // read back a fresh RAM store now and then
        if (op == mmwb_pkg::CMD_STORE && addr < mmwb_pkg::RAM_END &&
            $urandom_range(2) == 0)
        begin
            send_request(mmwb_pkg::CMD_LOAD, addr, $urandom());
        end
    endtask

    initial
    begin
        // Hold reset, then release at a falling edge
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 13;
        recv_idle_pct = 57;

        // Directed requests under the reset port addresses
        send_request(mmwb_pkg::CMD_LOAD,  32'd0,                        32'h0);
        send_request(mmwb_pkg::CMD_STORE, 32'd0,                        32'hFFFF_FFFF);
        send_request(mmwb_pkg::CMD_LOAD,  32'd0,                        32'h0);
        send_request(mmwb_pkg::CMD_STORE, 32'd1,                        32'h0000_0000);
        send_request(mmwb_pkg::CMD_LOAD,  32'd0,                        32'hFFFF_FFFF);
        send_request(mmwb_pkg::CMD_STORE, mmwb_pkg::RAM_LAST_START,     32'h0123_4567);
        send_request(mmwb_pkg::CMD_LOAD,  mmwb_pkg::RAM_LAST_START,     32'h0);
        send_request(mmwb_pkg::CMD_LOAD,  mmwb_pkg::RAM_LAST_START + 1, 32'h0);
        send_request(mmwb_pkg::CMD_STORE, mmwb_pkg::RAM_END - 1,        32'hA5A5_5A5A);
        send_request(mmwb_pkg::CMD_LOAD,  mmwb_pkg::RAM_LAST_START,     32'h0);
        send_request(mmwb_pkg::CMD_LOAD,  mmwb_pkg::CONSOLE_ADDR_RST,   32'hFFFF_FFFF);
        send_request(mmwb_pkg::CMD_STORE, mmwb_pkg::CONSOLE_ADDR_RST,   32'hDEAD_BEEF);
        send_request(mmwb_pkg::CMD_STORE, mmwb_pkg::CONSOLE_ADDR_RST,   32'h00FF_0080);
        send_request(mmwb_pkg::CMD_TICK,  32'd0,                        32'h0);
        send_request(mmwb_pkg::CMD_TICK,  32'hFFFF_FFFF,                32'hFFFF_FFFF);
        send_request(mmwb_pkg::CMD_TICK,  mmwb_pkg::TIMER_ADDR_RST,     32'h0);
        send_request(mmwb_pkg::CMD_LOAD,  mmwb_pkg::TIMER_ADDR_RST,     32'h0);
        send_request(mmwb_pkg::CMD_STORE, mmwb_pkg::TIMER_ADDR_RST,     32'h1234_5678);
        send_request(mmwb_pkg::CMD_LOAD,  32'hFFFF_FFFF,                32'h0);
        send_request(mmwb_pkg::CMD_STORE, 32'h8000_0000,                32'hFFFF_FFFF);
        send_request(CMD_UNUSED,          32'd0,                        32'hFFFF_FFFF);
        send_request(mmwb_pkg::CMD_LOAD,  32'd0,                        32'h0);
        send_request(mmwb_pkg::CMD_LOAD,  mmwb_pkg::TIMER_ADDR_RST + 1, 32'h0);
        send_request(mmwb_pkg::CMD_STORE, 32'd2,                        32'hA5A5_A5A5);
        send_request(mmwb_pkg::CMD_LOAD,  32'd1,                        32'h0);

        // Run the tick count through its wrap
        repeat (253) send_request(mmwb_pkg::CMD_TICK, $urandom(), $urandom());
        send_request(mmwb_pkg::CMD_LOAD, mmwb_pkg::TIMER_ADDR_RST, 32'h0);
        send_request(mmwb_pkg::CMD_TICK, 32'd0, 32'h0);
        send_request(mmwb_pkg::CMD_LOAD, mmwb_pkg::TIMER_ADDR_RST, 32'h0);
        wait_bus_quiet();

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            // Move the ports between phases, extremes first
            if (phase > 0)
            begin
                case (phase)
                    1:
                    begin
                        port_console = 32'hFFFF_FFFF;
                        port_timer   = 32'h0000_0000;
                    end
                    2:
                    begin
                        port_console = 32'h0000_0000;
                        port_timer   = 32'hFFFF_FFFF;
                    end
                    3:
                    begin
                        port_console = mmwb_pkg::RAM_END + $urandom_range(1023);
                        port_timer   = port_console;
                    end
                    default:
                    begin
                        port_console = $urandom();
                        port_timer   = $urandom();
                    end
                endcase
                access_register(1'b1, mmwb_pkg::REG_CONSOLE, port_console);
                access_register(1'b1, mmwb_pkg::REG_TIMER,   port_timer);
                access_register(1'b0, mmwb_pkg::REG_CONSOLE, 32'h0);
                access_register(1'b0, mmwb_pkg::REG_TIMER,   32'h0);
            end

            // Sender idles little first, then the receiver does, then neither
            if (phase < 2)
            begin
                send_idle_pct = 13;
                recv_idle_pct = 57;
            end
            else if (phase < 4)
            begin
                send_idle_pct = 57;
                recv_idle_pct = 13;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            repeat (PHASE_ITEMS) send_random_request();

            // Hold results off for a long stretch while console stores pile up
            if (phase == 1)
            begin
                in_valid <= 1'b0;
                hold_requests = hold_requests + 1;
                @(negedge clk);
                repeat (STALL_STORES)
                begin
                    send_request(mmwb_pkg::CMD_STORE, port_console, $urandom());
                end
            end

            // Pause the sender until every result is in
            wait_bus_quiet();
            repeat (PHASE_ITEMS) send_random_request();
            wait_bus_quiet();
        end

        if (fail_count == 0 && replies_due == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/mmwb_pkg.sv
rtl/mmwb_ram.sv
rtl/memory_mapped_word_bus.sv
bench/mmwb_result_checker.sv
bench/tb_memory_mapped_word_bus.sv
